// ===== src/mlp_input_gradient_unit_defines.svh =====
// Assertion macros used by the block's RTL.
`ifndef MLP_INPUT_GRADIENT_UNIT_DEFINES_SVH
`define MLP_INPUT_GRADIENT_UNIT_DEFINES_SVH
`define MIG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MIG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/mig_pkg.sv =====
package mig_pkg;
  localparam int MaxInputs = 16;
  localparam int MaxWidth = 16;
  localparam int MaxLayers = 4;
  localparam int WeightDepth = 2048;
  localparam int NodeDepth = MaxLayers * MaxWidth;
  localparam int JacDepth = NodeDepth * MaxInputs;
  localparam int WAddrW = $clog2(WeightDepth);
  localparam int NodeW = $clog2(NodeDepth);
  localparam int JacW = $clog2(JacDepth);
  localparam int InW = $clog2(MaxInputs);
  localparam int CntW = $clog2(MaxWidth + 1);
  localparam int LayW = $clog2(MaxLayers);
  localparam logic signed [31:0] QOne = 32'sh0100_0000;

  typedef enum logic [1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_LOAD_INPUT  = 2'd1,
    OP_COMPUTE     = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MODE_LOGISTIC = 2'd0,
    MODE_TANH     = 2'd1,
    MODE_RELU     = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_INPUTS  = 3'd1,
    REG_LAYERS  = 3'd2,
    REG_WIDTH_1 = 3'd3,
    REG_WIDTH_2 = 3'd4,
    REG_WIDTH_3 = 3'd5,
    REG_WIDTH_4 = 3'd6
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FWD_BIAS,
    ST_FWD_MAC,
    ST_FWD_ACT,
    ST_DER,
    ST_JAC_INIT,
    ST_JAC_MAC,
    ST_JAC_SCALE,
    ST_JAC_STORE,
    ST_EMIT
  } state_e;

  // Multiply-accumulate command from the sequencer.
  typedef struct packed {
    logic clear;
    logic load_bias;
    logic mac;
  } mac_ctl_t;

  function automatic logic [CntW-1:0] clamp_cnt(input logic [4:0] v);
    logic [CntW-1:0] r;
    if (v == 5'd0) r = CntW'(1);
    else if (32'(v) > MaxWidth) r = CntW'(MaxWidth);
    else r = CntW'(v);
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -48'sh0000_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [35:0] plan_logistic(input logic signed [35:0] x);
    logic signed [35:0] ax;
    logic signed [35:0] y;
    ax = x[35] ? -x : x;
    if (ax >= 36'sd83886080) y = 36'sd16777216;
    else if (ax >= 36'sd39845888) y = (ax >>> 5) + 36'sd14155776;
    else if (ax >= 36'sd16777216) y = (ax >>> 3) + 36'sd10485760;
    else y = (ax >>> 2) + 36'sd8388608;
    return x[35] ? 36'sd16777216 - y : y;
  endfunction

  function automatic logic signed [31:0] activate(input mode_e m,
                                                   input logic signed [31:0] x);
    logic signed [35:0] t;
    logic signed [31:0] r;
    case (m)
      MODE_LOGISTIC: begin
        t = plan_logistic(36'(x));
        r = t[31:0];
      end
      MODE_TANH: begin
        t = plan_logistic(36'(x) <<< 1);
        t = (t <<< 1) - 36'sd16777216;
        r = t[31:0];
      end
      default: r = x[31] ? 32'sd0 : x;
    endcase
    return r;
  endfunction
endpackage

// ===== src/mig_if.sv =====
interface mig_in_if;
  import mig_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] operation;
  logic [10:0] slot;
  logic signed [31:0] payload;
  modport source (output valid, operation, slot, payload, input ready);
  modport sink (input valid, operation, slot, payload, output ready);
endinterface

interface mig_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] gradient;
  logic [3:0] feature_index;
  logic last;
  modport source (output valid, gradient, feature_index, last, input ready);
  modport sink (input valid, gradient, feature_index, last, output ready);
endinterface

// ===== src/mig_mac.sv =====
module mig_mac import mig_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mac_ctl_t           ctl_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] sat_o,
  output logic signed [31:0] prod_o
);
  logic signed [63:0] prod;
  logic signed [47:0] acc_q, acc_d;
  logic signed [47:0] rnd;

  assign prod = 64'(a_i) * 64'(b_i) + 64'sd8388608;
  assign rnd = 48'(prod >>> 24);
  assign prod_o = sat32(rnd);

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clear) acc_d = '0;
    else if (ctl_i.load_bias) acc_d = 48'(a_i);
    else if (ctl_i.mac) acc_d = acc_q + rnd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) acc_q <= '0;
    else acc_q <= acc_d;
  end

  assign sat_o = sat32(acc_q);
endmodule

// ===== src/mlp_input_gradient_unit.sv =====
// Channel   Direction  Payload
// in_if     sink       operation, slot, payload
// out_if    source     gradient, feature_index, last
// cfg_*     write      register index, register data
// A compute item runs every product through one shared multiply-accumulate
// (store read, then accumulate), plus bookkeeping per node and per Jacobian
// entry. Each result can stall on out ready; the block is not ready during a
// compute. Reset is asynchronous and active low; it clears control only.
`include "mlp_input_gradient_unit_defines.svh"
module mlp_input_gradient_unit import mig_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mig_in_if.sink     in_if,
  mig_out_if.source  out_if,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [4:0] cfg_data_i
);
  // Configuration registers.
  logic [1:0] mode_q;
  logic [4:0] inputs_q, layers_q;
  logic [4:0] widths_q [MaxLayers];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LOGISTIC;
      inputs_q <= 5'd16;
      layers_q <= 5'd1;
      for (int i = 0; i < MaxLayers; i++) widths_q[i] <= 5'd16;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_index_i))
        REG_MODE: mode_q <= cfg_data_i[1:0];
        REG_INPUTS: inputs_q <= cfg_data_i;
        REG_LAYERS: layers_q <= {2'b00, cfg_data_i[2:0]};
        REG_WIDTH_1: widths_q[0] <= cfg_data_i;
        REG_WIDTH_2: widths_q[1] <= cfg_data_i;
        REG_WIDTH_3: widths_q[2] <= cfg_data_i;
        REG_WIDTH_4: widths_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mode_e mode;
  logic [CntW-1:0] p_cnt;
  logic [LayW:0] n_layers;
  assign mode = (mode_q == MODE_LOGISTIC) ? MODE_LOGISTIC :
                (mode_q == MODE_TANH) ? MODE_TANH : MODE_RELU;
  assign p_cnt = clamp_cnt(inputs_q);
  always_comb begin
    if (layers_q == 5'd0) n_layers = (LayW+1)'(1);
    else if (32'(layers_q) > MaxLayers) n_layers = (LayW+1)'(MaxLayers);
    else n_layers = layers_q[LayW:0];
  end

  // Sequencer state.
  state_e st_q, st_d;
  logic [LayW:0] lay_q;        // current layer; n_layers means output unit
  logic [CntW-1:0] node_q;     // node within layer
  logic [CntW-1:0] j_q;        // source index
  logic [CntW-1:0] k_q;        // input index for Jacobian
  logic [WAddrW:0] off_q;      // weight offset of current node
  logic [CntW-1:0] prev_q;
  logic signed [31:0] y_q, d_q;
  logic [1:0] ph_q;            // read latency phase

  logic [CntW-1:0] width_cur;
  logic at_out;
  assign at_out = (lay_q == n_layers);
  assign width_cur = at_out ? CntW'(1) : clamp_cnt(widths_q[lay_q[LayW-1:0]]);

  // Memories: read data registered.
  logic signed [31:0] wmem [WeightDepth];
  logic signed [31:0] imem [MaxInputs];
  logic signed [31:0] amem [NodeDepth];
  logic signed [31:0] jmem [JacDepth];
  logic signed [31:0] w_rd_q, i_rd_q, a_rd_q, j_rd_q;
  logic [WAddrW:0] w_addr;
  logic w_oob_q;
  logic [NodeW-1:0] a_raddr, a_waddr;
  logic [JacW-1:0] j_raddr, j_waddr;
  logic a_we, j_we;
  logic signed [31:0] j_wdata;

  logic in_fire;
  assign in_if.ready = (st_q == ST_IDLE);
  assign in_fire = in_if.valid && in_if.ready;

  // Weight read address: bias at off, weight j at off+1+j.
  always_comb begin
    case (st_q)
      ST_FWD_BIAS: w_addr = off_q;
      default: w_addr = off_q + (WAddrW+1)'(1) + (WAddrW+1)'(j_q);
    endcase
  end
  logic [LayW-1:0] lay_m1;
  assign lay_m1 = LayW'(lay_q - (LayW+1)'(1));
  assign a_raddr = NodeW'({lay_m1, j_q[InW-1:0]});
  assign a_waddr = NodeW'({lay_q[LayW-1:0], node_q[InW-1:0]});
  assign j_raddr = JacW'({lay_m1, j_q[InW-1:0], k_q[InW-1:0]});
  assign j_waddr = JacW'({lay_q[LayW-1:0], node_q[InW-1:0], k_q[InW-1:0]});

  always_ff @(posedge clk_i) begin
    if (in_fire && in_if.operation == OP_LOAD_WEIGHT)
      wmem[in_if.slot] <= in_if.payload;
    if (in_fire && in_if.operation == OP_LOAD_INPUT && in_if.slot < 11'(MaxInputs))
      imem[in_if.slot[InW-1:0]] <= in_if.payload;
    if (a_we) amem[a_waddr] <= y_q;
    if (j_we) jmem[j_waddr] <= j_wdata;
    w_rd_q <= wmem[w_addr[WAddrW-1:0]];
    w_oob_q <= w_addr[WAddrW];
    i_rd_q <= imem[j_q[InW-1:0]];
    a_rd_q <= amem[a_raddr];
    j_rd_q <= jmem[j_raddr];
  end

  logic signed [31:0] w_val;
  assign w_val = w_oob_q ? 32'sd0 : w_rd_q;

  // Shared multiply-accumulate.
  mac_ctl_t mctl;
  logic signed [31:0] ma, mb, acc_sat, prod_sat;
  mig_mac u_mac (
    .clk_i, .rst_ni, .ctl_i(mctl), .a_i(ma), .b_i(mb),
    .sat_o(acc_sat), .prod_o(prod_sat)
  );

  logic signed [31:0] src_val;
  assign src_val = (lay_q == '0) ? i_rd_q : a_rd_q;

  // Derivative operands; logistic and tanh need one product each.
  logic signed [31:0] one_m_y, one_p_y;
  assign one_m_y = sat32(48'(QOne) - 48'(y_q));
  assign one_p_y = sat32(48'(QOne) + 48'(y_q));

  logic out_v_q, out_last_q;
  logic signed [31:0] out_g_q;
  logic [3:0] out_k_q;
  logic jac_first;
  assign jac_first = (lay_q == '0);

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (in_fire && in_if.operation == OP_COMPUTE) st_d = ST_FWD_BIAS;
      ST_FWD_BIAS: if (ph_q == 2'd1) st_d = at_out ? ST_JAC_INIT : ST_FWD_MAC;
      ST_FWD_MAC: if (ph_q == 2'd1 && j_q == prev_q - CntW'(1)) st_d = ST_FWD_ACT;
      ST_FWD_ACT: st_d = ST_DER;
      ST_DER: if (ph_q == 2'd1) st_d = ST_JAC_INIT;
      ST_JAC_INIT: st_d = ST_JAC_MAC;
      ST_JAC_MAC: if (ph_q == 2'd1 && (jac_first || j_q == prev_q - CntW'(1)))
        st_d = ST_JAC_SCALE;
      ST_JAC_SCALE: st_d = at_out ? ST_EMIT : ST_JAC_STORE;
      ST_JAC_STORE: begin
        if (k_q != p_cnt - CntW'(1)) st_d = ST_JAC_INIT;
        else st_d = ST_FWD_BIAS;
      end
      ST_EMIT: if (out_if.ready || !out_v_q)
        st_d = (k_q == p_cnt - CntW'(1)) ? ST_IDLE : ST_JAC_INIT;
      default: st_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    mctl = '0;
    ma = w_val;
    mb = src_val;
    a_we = 1'b0;
    j_we = 1'b0;
    j_wdata = prod_sat;
    case (st_q)
      ST_FWD_BIAS: if (ph_q == 2'd1) mctl.load_bias = 1'b1;
      ST_FWD_MAC: if (ph_q == 2'd1) mctl.mac = 1'b1;
      ST_DER: begin
        ma = (mode == MODE_TANH) ? one_p_y : y_q;
        mb = one_m_y;
        // The activation is stored once the derivative is formed.
        if (ph_q == 2'd1) a_we = 1'b1;
      end
      ST_JAC_INIT: mctl.clear = 1'b1;
      ST_JAC_MAC: begin
        ma = w_val;
        mb = jac_first ? d_q : j_rd_q;
        if (ph_q == 2'd1) mctl.mac = 1'b1;
      end
      ST_JAC_SCALE: begin
        ma = d_q;
        mb = acc_sat;
      end
      ST_JAC_STORE: begin
        j_we = 1'b1;
        j_wdata = y_q;
      end
      default: ;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      lay_q <= '0; node_q <= '0; j_q <= '0; k_q <= '0;
      off_q <= '0; prev_q <= '0; ph_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_v_q && out_if.ready && st_q != ST_EMIT) out_v_q <= 1'b0;
      case (st_q)
        ST_IDLE: if (st_d == ST_FWD_BIAS) begin
          lay_q <= '0; node_q <= '0; j_q <= '0; k_q <= '0;
          off_q <= '0; prev_q <= p_cnt; ph_q <= '0;
        end
        ST_FWD_BIAS: begin
          ph_q <= (ph_q == 2'd1) ? 2'd0 : 2'd1;
          if (ph_q == 2'd1) begin
            j_q <= '0;
            k_q <= '0;
            if (at_out) d_q <= QOne;
          end
        end
        ST_FWD_MAC: begin
          ph_q <= (ph_q == 2'd1) ? 2'd0 : 2'd1;
          if (ph_q == 2'd1 && j_q != prev_q - CntW'(1)) j_q <= j_q + CntW'(1);
        end
        ST_FWD_ACT: begin
          y_q <= activate(mode, acc_sat);
          ph_q <= '0;
        end
        ST_DER: begin
          ph_q <= (ph_q == 2'd1) ? 2'd0 : 2'd1;
          if (ph_q == 2'd1) begin
            if (mode == MODE_RELU) d_q <= y_q[31] || y_q == '0 ? 32'sd0 : QOne;
            else d_q <= prod_sat;
            k_q <= '0;
          end
        end
        ST_JAC_INIT: begin
          j_q <= jac_first ? k_q : '0;
          ph_q <= '0;
        end
        ST_JAC_MAC: begin
          ph_q <= (ph_q == 2'd1) ? 2'd0 : 2'd1;
          if (ph_q == 2'd1 && !jac_first && j_q != prev_q - CntW'(1))
            j_q <= j_q + CntW'(1);
        end
        ST_JAC_SCALE: begin
          // At the output unit this is the gradient, held until the output
          // register is free.
          y_q <= jac_first ? acc_sat : prod_sat;
        end
        ST_JAC_STORE: begin
          if (k_q != p_cnt - CntW'(1)) k_q <= k_q + CntW'(1);
          else begin
            k_q <= '0;
            j_q <= '0;
            off_q <= off_q + (WAddrW+1)'(prev_q) + (WAddrW+1)'(1);
            if (node_q != width_cur - CntW'(1)) node_q <= node_q + CntW'(1);
            else begin
              node_q <= '0;
              prev_q <= width_cur;
              lay_q <= lay_q + (LayW+1)'(1);
            end
          end
        end
        ST_EMIT: if (out_if.ready || !out_v_q) begin
          out_v_q <= 1'b1;
          out_g_q <= y_q;
          out_k_q <= k_q[3:0];
          out_last_q <= (k_q == p_cnt - CntW'(1));
          k_q <= k_q + CntW'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_if.valid = out_v_q;
  assign out_if.gradient = out_g_q;
  assign out_if.feature_index = out_k_q;
  assign out_if.last = out_last_q;

  `MIG_ASSERT_IMP(a_busy_not_ready, clk_i, rst_ni, st_q != ST_IDLE, !in_if.ready)
  `MIG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_v_q && !out_if.ready, out_v_q)
  `MIG_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_v_q && !out_if.ready, $stable(out_g_q))
endmodule

// ===== bench/mlp_input_gradient_unit_tb.sv =====
`timescale 1ns / 1ps

module mlp_input_gradient_unit_tb;
  import mig_pkg::*;

  // Code with no operation behind it; the block must drop such an item.
  localparam logic [1:0] OpUnused = 2'd3;
  // Register index beyond the last register; the write must be ignored.
  localparam logic [2:0] RegUnused = 3'd7;
  localparam longint QUnit = 64'sd16777216;

  typedef struct {
    logic [1:0]         op;
    logic [10:0]        slot;
    logic signed [31:0] value;
  } load_item_t;

  typedef struct {
    logic signed [31:0] gradient;
    logic [3:0]         feature;
    logic               last;
  } grad_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_index_i;
  logic [4:0] cfg_data_i;

  mig_in_if  in_ch ();
  mig_out_if out_ch ();

  mlp_input_gradient_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Items waiting to be driven, and gradients still owed by the block.
  load_item_t item_q[$];
  grad_t      gradient_q[$];
  int         error_count = 0;
  bit         calm = 0;
  // Leading weight and input slots already written at least once.
  int         loaded_weights = 0;
  int         loaded_inputs = 0;

  // Shadow of the network as the block should hold it.
  logic [4:0]         reg_shadow[7];
  logic signed [31:0] weight_mem[WeightDepth];
  logic signed [31:0] feature_mem[MaxInputs];
  logic signed [31:0] act_mem[NodeDepth];
  logic signed [31:0] jac_mem[JacDepth];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Fixed-point helpers. Products round half up, sums saturate to 32 bits.
  // ---------------------------------------------------------------------------
  function automatic longint q_mul(input logic signed [31:0] a, input logic signed [31:0] b);
    return (longint'(a) * longint'(b) + 64'sd8388608) >>> 24;
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint sigmoid_plan(input longint x);
    longint ax;
    longint y;
    ax = (x < 0) ? -x : x;
    if (ax >= 5 * QUnit) y = QUnit;
    else if (ax >= 64'sd39845888) y = (ax >>> 5) + 64'sd14155776;
    else if (ax >= QUnit) y = (ax >>> 3) + 64'sd10485760;
    else y = (ax >>> 2) + 64'sd8388608;
    return (x < 0) ? QUnit - y : y;
  endfunction

  // Effective settings: out-of-range register values clamp into range, and
  // mode three behaves as relu.
  function automatic mode_e eff_mode();
    return (reg_shadow[REG_MODE][1:0] > 2'd2) ? MODE_RELU : mode_e'(reg_shadow[REG_MODE][1:0]);
  endfunction

  function automatic int clamp_int(input int v, input int lo, input int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int eff_inputs();
    return clamp_int(reg_shadow[REG_INPUTS], 1, MaxInputs);
  endfunction

  function automatic int eff_layers();
    return clamp_int(reg_shadow[REG_LAYERS][2:0], 1, MaxLayers);
  endfunction

  function automatic int eff_width(input int layer);
    return clamp_int(reg_shadow[int'(REG_WIDTH_1) + layer], 1, MaxWidth);
  endfunction

  function automatic logic signed [31:0] squash(input mode_e m, input logic signed [31:0] x);
    case (m)
      MODE_LOGISTIC: return 32'(sigmoid_plan(longint'(x)));
      MODE_TANH: return 32'(2 * sigmoid_plan(2 * longint'(x)) - QUnit);
      default: return (x > 0) ? x : 32'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] slope(input mode_e m, input logic signed [31:0] y);
    case (m)
      MODE_LOGISTIC: return clip32(q_mul(y, clip32(QUnit - longint'(y))));
      MODE_TANH: return clip32(q_mul(clip32(QUnit + longint'(y)), clip32(QUnit - longint'(y))));
      default: return (y > 0) ? QOne : 32'sd0;
    endcase
  endfunction

  // Number of leading weight slots that a compute reads with the current setup.
  function automatic int weights_used();
    int prev;
    int total;
    prev = eff_inputs();
    total = 0;
    for (int l = 0; l < eff_layers(); l++) begin
      total += (prev + 1) * eff_width(l);
      prev = eff_width(l);
    end
    return total + prev + 1;
  endfunction

  // Forward pass, then the input Jacobian carried layer by layer; the output
  // unit is linear, so its gradient row is a plain weighted sum.
  task automatic predict_gradients();
    mode_e m;
    int p;
    int layers;
    int prev;
    int off;
    int node;
    longint acc;
    logic signed [31:0] src;
    logic signed [31:0] y;
    logic signed [31:0] d;
    grad_t g;
    m = eff_mode();
    p = eff_inputs();
    layers = eff_layers();
    prev = p;
    off = 0;
    for (int l = 0; l < layers; l++) begin
      for (int i = 0; i < eff_width(l); i++) begin
        node = l * MaxWidth + i;
        acc = longint'(weight_mem[off]);
        for (int j = 0; j < prev; j++) begin
          src = (l == 0) ? feature_mem[j] : act_mem[(l - 1) * MaxWidth + j];
          acc += q_mul(src, weight_mem[off + 1 + j]);
        end
        y = squash(m, clip32(acc));
        d = slope(m, y);
        act_mem[node] = y;
        for (int k = 0; k < p; k++) begin
          if (l == 0) begin
            jac_mem[node * MaxInputs + k] = clip32(q_mul(d, weight_mem[off + 1 + k]));
          end else begin
            acc = 0;
            for (int j = 0; j < prev; j++)
              acc += q_mul(weight_mem[off + 1 + j],
                           jac_mem[((l - 1) * MaxWidth + j) * MaxInputs + k]);
            jac_mem[node * MaxInputs + k] = clip32(q_mul(d, clip32(acc)));
          end
        end
        off += prev + 1;
      end
      prev = eff_width(l);
    end
    for (int k = 0; k < p; k++) begin
      acc = 0;
      for (int j = 0; j < prev; j++)
        acc += q_mul(weight_mem[off + 1 + j],
                     jac_mem[((layers - 1) * MaxWidth + j) * MaxInputs + k]);
      g.gradient = clip32(acc);
      g.feature = 4'(k);
      g.last = (k + 1 == p);
      gradient_q.push_back(g);
    end
  endtask

  task automatic apply_item(input load_item_t it);
    case (it.op)
      OP_LOAD_WEIGHT: weight_mem[it.slot] = it.value;
      OP_LOAD_INPUT: if (it.slot < MaxInputs) feature_mem[it.slot] = it.value;
      OP_COMPUTE: predict_gradients();
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: a new item goes out once the previous transfer has completed or the
  // channel was idle. Prediction happens at the edge where a transfer occurs.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    load_item_t it;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.operation <= OP_LOAD_WEIGHT;
      in_ch.slot <= '0;
      in_ch.payload <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        it.op = in_ch.operation;
        it.slot = in_ch.slot;
        it.value = in_ch.payload;
        apply_item(it);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (item_q.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
          it = item_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.operation <= it.op;
          in_ch.slot <= it.slot;
          in_ch.payload <= it.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every gradient transfer is checked against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    grad_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 22);
      if (out_ch.valid && out_ch.ready) begin
        if (gradient_q.size() == 0) begin
          report_mismatch("unexpected gradient", out_ch.gradient, 0);
        end else begin
          want = gradient_q.pop_front();
          if (out_ch.gradient !== want.gradient)
            report_mismatch("gradient", out_ch.gradient, want.gradient);
          if (out_ch.feature_index !== want.feature)
            report_mismatch("feature_index", out_ch.feature_index, want.feature);
          if (out_ch.last !== want.last)
            report_mismatch("last", out_ch.last, want.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'($urandom_range(0, 1 << 28)) - 32'sd134217728;
      default: return 32'($urandom_range(0, 1 << 26)) - 32'sd33554432;
    endcase
  endfunction

  task automatic push_item(input logic [1:0] op, input int slot, input logic signed [31:0] v);
    load_item_t it;
    it.op = op;
    it.slot = 11'(slot);
    it.value = v;
    item_q.push_back(it);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [4:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    if (idx <= REG_WIDTH_4) reg_shadow[idx] = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Registers change only with the block idle: nothing queued, nothing in
  // flight, every gradient in, plus a margin for the trailing pipeline.
  task automatic wait_idle();
    wait (item_q.size() == 0 && !in_ch.valid && gradient_q.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  // One phase: program the network shape, load the weights and inputs that the
  // computes will read and that no earlier phase has written, then run a few
  // computes with partial reloads and noise (dropped operations and
  // out-of-range input slots) in between.
  task automatic run_phase(input logic [4:0] mode, input logic [4:0] inputs,
                           input logic [4:0] layers, input logic [4:0] w1,
                           input logic [4:0] w2, input logic [4:0] w3,
                           input logic [4:0] w4, input int computes);
    int used;
    wait_idle();
    write_reg(REG_MODE, mode);
    write_reg(REG_INPUTS, inputs);
    write_reg(REG_LAYERS, layers);
    write_reg(REG_WIDTH_1, w1);
    write_reg(REG_WIDTH_2, w2);
    write_reg(REG_WIDTH_3, w3);
    write_reg(REG_WIDTH_4, w4);
    used = weights_used();
    for (int i = loaded_weights; i < used; i++) push_item(OP_LOAD_WEIGHT, i, rand_q());
    if (used > loaded_weights) loaded_weights = used;
    for (int k = loaded_inputs; k < eff_inputs(); k++) push_item(OP_LOAD_INPUT, k, rand_q());
    if (eff_inputs() > loaded_inputs) loaded_inputs = eff_inputs();
    for (int c = 0; c < computes; c++) begin
      if (c != 0) begin
        repeat ($urandom_range(1, 2)) push_item(OP_LOAD_WEIGHT, $urandom_range(used - 1), rand_q());
        repeat ($urandom_range(0, 1))
          push_item(OP_LOAD_INPUT, $urandom_range(eff_inputs() - 1), rand_q());
      end
      case ($urandom_range(5))
        0: push_item(OpUnused, $urandom_range(2047), $urandom);
        1: push_item(OP_LOAD_INPUT, $urandom_range(MaxInputs, 2047), $urandom);
        default: ;
      endcase
      push_item(OP_COMPUTE, $urandom_range(2047), $urandom);
    end
  endtask

  initial begin
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    reg_shadow = '{5'd0, 5'd16, 5'd1, 5'd16, 5'd16, 5'd16, 5'd16};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Smallest net with saturating extremes: single input, single node. The
    // top weight slot and full-scale payloads also get written.
    run_phase(5'd0, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 1);
    push_item(OP_LOAD_WEIGHT, 2047, 32'sh7FFF_FFFF);
    push_item(OP_LOAD_WEIGHT, 2047, 32'sh8000_0000);
    push_item(OP_LOAD_WEIGHT, 1, 32'sh7FFF_FFFF);
    push_item(OP_LOAD_WEIGHT, 2, 32'sh7FFF_FFFF);
    push_item(OP_LOAD_INPUT, 0, 32'sh7FFF_FFFF);
    push_item(OP_COMPUTE, 0, '0);
    push_item(OP_LOAD_INPUT, 0, 32'sh8000_0000);
    push_item(OP_COMPUTE, 0, '0);

    // All sixteen inputs into a narrow layer in tanh, deepest narrow stack in
    // relu without stalls.
    run_phase(5'd1, 5'd16, 5'd1, 5'd3, 5'd3, 5'd3, 5'd3, 2);
    calm = 1;
    run_phase(5'd2, 5'd16, 5'd4, 5'd1, 5'd1, 5'd1, 5'd1, 2);
    wait_idle();
    calm = 0;

    // Out-of-range settings: mode three, oversized counts, zero widths, and a
    // write to an index that does not exist.
    write_reg(RegUnused, 5'd31);
    run_phase(5'd3, 5'd31, 5'd7, 5'd0, 5'd17, 5'd0, 5'd1, 2);
    run_phase(5'd0, 5'd0, 5'd0, 5'd4, 5'd1, 5'd1, 5'd1, 2);

    // Random networks, kept small.
    for (int ph = 0; ph < 4; ph++)
      run_phase(5'($urandom_range(3)), 5'($urandom_range(1, 6)), 5'($urandom_range(1, 4)),
                5'($urandom_range(1, 3)), 5'($urandom_range(1, 3)), 5'($urandom_range(1, 3)),
                5'($urandom_range(1, 3)), $urandom_range(1, 2));

    wait_idle();
    repeat (200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
